[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh: concurrent assertion helpers
// Implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/capm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capm_pkg: cascaded attitude controller package
// Register indexes, item kinds, fixed-point constants and per-axis step
// functions shared by the controller core.
// ----------------------------------------------------------------------------
package capm_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ROLL_KP     = 3'd0;
  localparam logic [2:0] REG_ROLL_KI_DT  = 3'd1;
  localparam logic [2:0] REG_ROLL_KD     = 3'd2;
  localparam logic [2:0] REG_PITCH_KP    = 3'd3;
  localparam logic [2:0] REG_PITCH_KI_DT = 3'd4;
  localparam logic [2:0] REG_PITCH_KD    = 3'd5;
  localparam logic [2:0] REG_RATE_KI_DT  = 3'd6;
  localparam logic [2:0] REG_THROTTLE    = 3'd7;

  // Item kinds carried on tuser
  localparam logic CMD_ANGLE = 1'b0;
  localparam logic CMD_RATE  = 1'b1;

  // Reset values of the registers
  localparam logic [31:0] RST_KP      = 32'd33554432;  // 2.0 in Q8.24
  localparam logic [31:0] RST_KI_DT   = 32'd42950;
  localparam logic [31:0] RST_KD      = 32'd3355443;   // 0.2 in Q8.24
  localparam logic [31:0] RST_RATE_KI = 32'd4295;
  localparam logic [11:0] RST_THROTTLE = 12'd1000;

  // Rate loop P gain, 0.3 in Q8.24
  localparam logic [31:0] RATE_KP_Q24 = 32'd5033165;

  // Right shifts of each gain product
  localparam logic [5:0] SH_ANG_P  = 6'd26;
  localparam logic [5:0] SH_ANG_I  = 6'd31;
  localparam logic [5:0] SH_ANG_D  = 6'd24;
  localparam logic [5:0] SH_RATE_P = 6'd28;
  localparam logic [5:0] SH_RATE_I = 6'd33;

  localparam logic [11:0] MOTOR_MAX = 12'd4095;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [31:0] sum;
    logic signed [23:0] cmd;
  } ang_res_t;

  typedef struct packed {
    logic signed [23:0] err;
    logic signed [39:0] sum;
    logic signed [40:0] corr;
  } rate_res_t;

  // g * v >> s, truncated toward zero. Split into two 32x21 / 32x20 partial
  // products; the caller keeps the shifted magnitude below 2^39.
  function automatic logic signed [39:0] capm_mulsh(input logic [31:0] g,
                                                   input logic signed [40:0] v,
                                                   input logic [5:0] s);
    logic        neg;
    logic [40:0] m;
    logic [52:0] a;
    logic [51:0] b;
    logic [53:0] t;
    logic [53:0] r;
    neg = v[40];
    m   = neg ? 41'(-v) : 41'(v);
    a   = 53'(g) * 53'(m[40:20]);
    b   = 52'(g) * 52'(m[19:0]);
    t   = 54'(a) + 54'(b[51:20]);
    r   = t >> (s - 6'd20);
    return neg ? -$signed(r[39:0]) : $signed(r[39:0]);
  endfunction

  // Angle loop for one axis: trapezoid integral, then P + I - D on rate.
  function automatic ang_res_t capm_angle_step(input logic signed [14:0] ang,
                                               input logic [31:0] kp,
                                               input logic [31:0] kidt,
                                               input logic [31:0] kd,
                                               input logic signed [15:0] last_rate,
                                               input logic signed [15:0] err,
                                               input logic signed [31:0] sum);
    ang_res_t           res;
    logic signed [15:0] e;
    logic signed [33:0] s34;
    logic signed [41:0] c;
    e   = -16'(ang);
    s34 = 34'(sum) + 34'(err) + 34'(e);
    if (s34[33:31] != {3{s34[31]}}) begin
      res.sum = s34[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      res.sum = s34[31:0];
    end
    res.err = e;
    c = 42'(capm_mulsh(kp, 41'(e), SH_ANG_P))
      + 42'(capm_mulsh(kidt, 41'(res.sum), SH_ANG_I))
      - 42'(capm_mulsh(kd, 41'(last_rate), SH_ANG_D));
    if (c[41:23] != {19{c[23]}}) begin
      res.cmd = c[41] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    end else begin
      res.cmd = c[23:0];
    end
    return res;
  endfunction

  // Rate loop for one axis: saturated error, trapezoid integral, PI output.
  function automatic rate_res_t capm_rate_step(input logic signed [15:0] rate,
                                               input logic signed [23:0] cmd,
                                               input logic [31:0] kidt,
                                               input logic signed [23:0] err,
                                               input logic signed [39:0] sum);
    rate_res_t          res;
    logic signed [24:0] d;
    logic signed [41:0] s42;
    d = 25'(cmd) - 25'(rate);
    if (d[24] != d[23]) begin
      res.err = d[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    end else begin
      res.err = d[23:0];
    end
    s42 = 42'(sum) + 42'(err) + 42'(res.err);
    if (s42[41:39] != {3{s42[39]}}) begin
      res.sum = s42[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      res.sum = s42[39:0];
    end
    res.corr = 41'(capm_mulsh(RATE_KP_Q24, 41'(res.err), SH_RATE_P))
             + 41'(capm_mulsh(kidt, 41'(res.sum), SH_RATE_I));
    return res;
  endfunction

  // Saturate a signed motor command to 0..4095.
  function automatic logic [11:0] capm_motor(input logic signed [41:0] x);
    logic [11:0] r;
    if (x[41]) begin
      r = 12'd0;
    end else if (x[40:12] != 29'd0) begin
      r = MOTOR_MAX;
    end else begin
      r = x[11:0];
    end
    return r;
  endfunction

endpackage

[src/cascaded_attitude_pid_mixer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_attitude_pid_mixer_core: two-axis cascaded attitude controller
// Angle PID loop feeding a rate PI loop, mixed into four motor commands.
// ----------------------------------------------------------------------------
// Usage:
//   Sensor beats enter on the s_axis channel. tuser selects the kind: an angle
//   beat updates the angle integrals and the rate commands and produces no
//   output; a rate beat runs the rate loop and produces one beat of four
//   saturated motor commands on the m_axis channel.
//   Gains and the throttle offset are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle; a write takes effect on the next edge.
// Throughput:
//   A rate beat moves from the input register into the result register, which
//   offers it on m_axis. One beat per cycle is sustained while m_axis is not
//   stalled; all per-axis arithmetic sits between the input register and the
//   loop state, so each beat sees the state left by the one before it.
// Stalls:
//   While m_axis is stalled the result register holds. Angle beats still drain
//   past it; a rate beat waits in the input register, and s_axis_tready drops
//   only while that register is full and cannot advance.
// Reset:
//   rst_ni clears all loop state to zero, loads the register defaults and
//   empties both stages.
// ----------------------------------------------------------------------------
module cascaded_attitude_pid_mixer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sensor beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [14:0] angle_roll, [29:15] angle_pitch, [45:30] rate_roll,
  // [61:46] rate_pitch, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  // Motor beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] motor_roll_plus, [23:12] motor_pitch_plus,
  // [35:24] motor_roll_minus, [47:36] motor_pitch_minus
  output logic [47:0] m_axis_tdata,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import capm_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  logic [31:0] roll_kp_q, roll_ki_dt_q, roll_kd_q;
  logic [31:0] pitch_kp_q, pitch_ki_dt_q, pitch_kd_q;
  logic [31:0] rate_ki_dt_q;
  logic [11:0] throttle_q;

  // Input register
  logic               in_valid_q;
  logic               in_cmd_q;
  logic signed [14:0] in_ang_roll_q, in_ang_pitch_q;
  logic signed [15:0] in_rate_roll_q, in_rate_pitch_q;

  // Loop state
  logic signed [15:0] ang_err_roll_q, ang_err_pitch_q;
  logic signed [31:0] ang_sum_roll_q, ang_sum_pitch_q;
  logic signed [23:0] rate_cmd_roll_q, rate_cmd_pitch_q;
  logic signed [15:0] last_rate_roll_q, last_rate_pitch_q;
  logic signed [23:0] rate_err_roll_q, rate_err_pitch_q;
  logic signed [39:0] rate_sum_roll_q, rate_sum_pitch_q;

  // Result register
  logic        out_valid_q;
  logic [47:0] out_data_q;

  ang_res_t    ang_roll, ang_pitch;
  rate_res_t   rate_roll, rate_pitch;
  logic        adv;
  logic [47:0] out_data_d;
  logic signed [41:0] off;

  // An angle beat never occupies the output, so it may advance under a stall.
  assign adv = in_valid_q && ((in_cmd_q == CMD_ANGLE) || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Per-axis loops, all against the current state
  always_comb begin
    ang_roll  = capm_angle_step(in_ang_roll_q, roll_kp_q, roll_ki_dt_q, roll_kd_q,
                                last_rate_roll_q, ang_err_roll_q, ang_sum_roll_q);
    ang_pitch = capm_angle_step(in_ang_pitch_q, pitch_kp_q, pitch_ki_dt_q, pitch_kd_q,
                                last_rate_pitch_q, ang_err_pitch_q, ang_sum_pitch_q);
    rate_roll  = capm_rate_step(in_rate_roll_q, rate_cmd_roll_q, rate_ki_dt_q,
                                rate_err_roll_q, rate_sum_roll_q);
    rate_pitch = capm_rate_step(in_rate_pitch_q, rate_cmd_pitch_q, rate_ki_dt_q,
                                rate_err_pitch_q, rate_sum_pitch_q);
  end

  // Mix the corrections about the throttle offset
  always_comb begin
    off = $signed({30'd0, throttle_q});
    out_data_d[11:0]  = capm_motor(off + 42'(rate_roll.corr));
    out_data_d[23:12] = capm_motor(off + 42'(rate_pitch.corr));
    out_data_d[35:24] = capm_motor(off - 42'(rate_roll.corr));
    out_data_d[47:36] = capm_motor(off - 42'(rate_pitch.corr));
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_kp_q     <= RST_KP;
      roll_ki_dt_q  <= RST_KI_DT;
      roll_kd_q     <= RST_KD;
      pitch_kp_q    <= RST_KP;
      pitch_ki_dt_q <= RST_KI_DT;
      pitch_kd_q    <= RST_KD;
      rate_ki_dt_q  <= RST_RATE_KI;
      throttle_q    <= RST_THROTTLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROLL_KP:     roll_kp_q     <= cfg_data_i;
        REG_ROLL_KI_DT:  roll_ki_dt_q  <= cfg_data_i;
        REG_ROLL_KD:     roll_kd_q     <= cfg_data_i;
        REG_PITCH_KP:    pitch_kp_q    <= cfg_data_i;
        REG_PITCH_KI_DT: pitch_ki_dt_q <= cfg_data_i;
        REG_PITCH_KD:    pitch_kd_q    <= cfg_data_i;
        REG_RATE_KI_DT:  rate_ki_dt_q  <= cfg_data_i;
        REG_THROTTLE:    throttle_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Input register: load on accept, drop once the beat advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q        <= s_axis_tuser;
      in_ang_roll_q   <= s_axis_tdata[14:0];
      in_ang_pitch_q  <= s_axis_tdata[29:15];
      in_rate_roll_q  <= s_axis_tdata[45:30];
      in_rate_pitch_q <= s_axis_tdata[61:46];
    end
  end

  // Loop state: advance with each beat of its own kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_err_roll_q    <= '0;
      ang_err_pitch_q   <= '0;
      ang_sum_roll_q    <= '0;
      ang_sum_pitch_q   <= '0;
      rate_cmd_roll_q   <= '0;
      rate_cmd_pitch_q  <= '0;
      last_rate_roll_q  <= '0;
      last_rate_pitch_q <= '0;
      rate_err_roll_q   <= '0;
      rate_err_pitch_q  <= '0;
      rate_sum_roll_q   <= '0;
      rate_sum_pitch_q  <= '0;
    end else if (adv) begin
      if (in_cmd_q == CMD_ANGLE) begin
        ang_err_roll_q   <= ang_roll.err;
        ang_err_pitch_q  <= ang_pitch.err;
        ang_sum_roll_q   <= ang_roll.sum;
        ang_sum_pitch_q  <= ang_pitch.sum;
        rate_cmd_roll_q  <= ang_roll.cmd;
        rate_cmd_pitch_q <= ang_pitch.cmd;
      end else begin
        last_rate_roll_q  <= in_rate_roll_q;
        last_rate_pitch_q <= in_rate_pitch_q;
        rate_err_roll_q   <= rate_roll.err;
        rate_err_pitch_q  <= rate_pitch.err;
        rate_sum_roll_q   <= rate_roll.sum;
        rate_sum_pitch_q  <= rate_pitch.sum;
      end
    end
  end

  // Result register: fill on a rate beat, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && (in_cmd_q == CMD_RATE)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (in_cmd_q == CMD_RATE)) begin
      out_data_q <= out_data_d;
    end
  end

  // A rate beat that advances must show up as a motor beat next cycle
  `ASSERT_NEXT(a_rate_beat_out, adv && (in_cmd_q == CMD_RATE), m_axis_tvalid,
               "rate beat advanced without a motor beat")
  // An empty input register always takes a beat
  `ASSERT_IMPL(a_ready_when_empty, !in_valid_q, s_axis_tready,
               "input register empty but not ready")
  // A beat held in the input register is not lost
  `ASSERT_NEXT(a_hold_input, in_valid_q && !adv, in_valid_q,
               "stalled input beat dropped")

endmodule
